### hw/rtl/sgp_pkg.sv
// Shared constants, types and the arctangent table of the standoff goal pipeline.
package sgp_pkg;

  // CORDIC iterations in each of the two CORDIC pipelines
  localparam int CORDIC_STAGES = 24;
  // fraction bits of a position
  localparam int POS_FRAC_BITS = 16;
  // quotient bits of the offset divider, one per stage; also carries the rotation CORDIC
  localparam int DIV_BITS      = 33;

  // vectoring datapath width, angle width, rotation width, distance width
  localparam int CW  = 36;
  localparam int ZW  = 34;
  localparam int RW  = 34;
  localparam int DW  = 34;
  // numerator width and standoff register width
  localparam int NW  = 64;
  localparam int SDW = 31;

  localparam logic [29:0]           GAIN_INV     = 30'd652032874;
  localparam logic signed [ZW-1:0]  HALF_PI      = ZW'(1686629713);
  localparam logic signed [RW-1:0]  ROT_START    = RW'(652032874);
  localparam logic signed [RW-1:0]  Q30_ONE      = RW'(1073741824);
  localparam logic [SDW-1:0]        STANDOFF_RST = SDW'(1) << (POS_FRAC_BITS - 1);

  // object pose and offset signs that travel beside the arithmetic
  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] qz;
    logic signed [31:0] qw;
    logic               dxn;
    logic               dyn;
    logic [31:0]        ax;
    logic [31:0]        ay;
  } side_t;

  // arctangent of 2^-i in Q30 radians
  function automatic logic signed [ZW-1:0] atan_q30(input int unsigned i);
    logic signed [ZW-1:0] r;
    case (i)
      0:  r = ZW'(843314856);
      1:  r = ZW'(497837829);
      2:  r = ZW'(263043836);
      3:  r = ZW'(133525158);
      4:  r = ZW'(67021686);
      5:  r = ZW'(33543515);
      6:  r = ZW'(16775850);
      7:  r = ZW'(8388437);
      8:  r = ZW'(4194282);
      9:  r = ZW'(2097149);
      10: r = ZW'(1048576);
      default: begin
        if (i <= 30) r = ZW'(1) << (30 - i);
        else r = '0;
      end
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/sgp_if.sv
// Input and result channel interfaces of the standoff goal block.
interface sgp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] object_x;
  logic signed [31:0] object_y;
  logic signed [31:0] object_quat_z;
  logic signed [31:0] object_quat_w;
  logic signed [31:0] robot_x;
  logic signed [31:0] robot_y;
  logic               robot_valid;

  modport source(output valid, object_x, object_y, object_quat_z, object_quat_w,
                 robot_x, robot_y, robot_valid, input ready);
  modport sink(input valid, object_x, object_y, object_quat_z, object_quat_w,
               robot_x, robot_y, robot_valid, output ready);
endinterface

interface sgp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] goal_x;
  logic signed [31:0] goal_y;
  logic signed [31:0] goal_quat_z;
  logic signed [31:0] goal_quat_w;
  logic               offset_applied;

  modport source(output valid, goal_x, goal_y, goal_quat_z, goal_quat_w, offset_applied,
                 input ready);
  modport sink(input valid, goal_x, goal_y, goal_quat_z, goal_quat_w, offset_applied,
               output ready);
endinterface

### hw/rtl/sgp_vec.sv
// Vectoring CORDIC pipeline: one iteration per register stage.
module sgp_vec import sgp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_v,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  input  side_t                side_in,
  output logic                 out_v,
  output logic signed [CW-1:0] x_out,
  output logic signed [ZW-1:0] z_out,
  output side_t                side_out
);

  logic                 v_r [0:CORDIC_STAGES];
  logic signed [CW-1:0] x_r [0:CORDIC_STAGES];
  logic signed [CW-1:0] y_r [0:CORDIC_STAGES];
  logic signed [ZW-1:0] z_r [0:CORDIC_STAGES];
  side_t                s_r [0:CORDIC_STAGES];

  // capture the pre-rotated vector
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= x_in;
      y_r[0] <= y_in;
      z_r[0] <= z_in;
      s_r[0] <= side_in;
    end
  end

  // drive y toward zero, accumulating the angle
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_iter
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g+1] <= 1'b0;
      end else if (en) begin
        v_r[g+1] <= v_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (y_r[g] < 0) begin
          x_r[g+1] <= x_r[g] - (y_r[g] >>> g);
          y_r[g+1] <= y_r[g] + (x_r[g] >>> g);
          z_r[g+1] <= z_r[g] - atan_q30(g);
        end else begin
          x_r[g+1] <= x_r[g] + (y_r[g] >>> g);
          y_r[g+1] <= y_r[g] - (x_r[g] >>> g);
          z_r[g+1] <= z_r[g] + atan_q30(g);
        end
        s_r[g+1] <= s_r[g];
      end
    end
  end

  assign out_v    = v_r[CORDIC_STAGES];
  assign x_out    = x_r[CORDIC_STAGES];
  assign z_out    = z_r[CORDIC_STAGES];
  assign side_out = s_r[CORDIC_STAGES];

endmodule

### hw/rtl/sgp_divrot.sv
// Offset divider (one quotient bit per stage) beside the half-yaw rotation CORDIC.
module sgp_divrot import sgp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_v,
  input  logic [NW-1:0]        nx_in,
  input  logic [NW-1:0]        ny_in,
  input  logic [DW-1:0]        dist_in,
  input  logic signed [ZW-1:0] zh_in,
  input  logic                 applied_in,
  input  side_t                side_in,
  output logic                 out_v,
  output logic [DIV_BITS-1:0]  qx_out,
  output logic [DIV_BITS-1:0]  qy_out,
  output logic signed [RW-1:0] cx_out,
  output logic signed [RW-1:0] cy_out,
  output logic                 applied_out,
  output side_t                side_out
);

  logic                 v_r    [0:DIV_BITS];
  logic [DW-1:0]        remx_r [0:DIV_BITS];
  logic [DW-1:0]        remy_r [0:DIV_BITS];
  logic [DIV_BITS-1:0]  nlx_r  [0:DIV_BITS];
  logic [DIV_BITS-1:0]  nly_r  [0:DIV_BITS];
  logic [DIV_BITS-1:0]  qx_r   [0:DIV_BITS];
  logic [DIV_BITS-1:0]  qy_r   [0:DIV_BITS];
  logic [DW-1:0]        dist_r [0:DIV_BITS];
  logic signed [RW-1:0] cx_r   [0:DIV_BITS];
  logic signed [RW-1:0] cy_r   [0:DIV_BITS];
  logic signed [ZW-1:0] cz_r   [0:DIV_BITS];
  logic                 ap_r   [0:DIV_BITS];
  side_t                s_r    [0:DIV_BITS];

  // load numerators and the rotation start vector
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      remx_r[0] <= DW'(nx_in[NW-1:DIV_BITS]);
      remy_r[0] <= DW'(ny_in[NW-1:DIV_BITS]);
      nlx_r[0]  <= nx_in[DIV_BITS-1:0];
      nly_r[0]  <= ny_in[DIV_BITS-1:0];
      qx_r[0]   <= '0;
      qy_r[0]   <= '0;
      dist_r[0] <= dist_in;
      cx_r[0]   <= ROT_START;
      cy_r[0]   <= '0;
      cz_r[0]   <= zh_in;
      ap_r[0]   <= applied_in;
      s_r[0]    <= side_in;
    end
  end

  for (genvar g = 0; g < DIV_BITS; g++) begin : g_step
    logic [DW:0] tx;
    logic [DW:0] ty;
    logic        gex;
    logic        gey;

    // shift in the next numerator bit and try the subtraction
    assign tx  = {remx_r[g], nlx_r[g][DIV_BITS-1-g]};
    assign ty  = {remy_r[g], nly_r[g][DIV_BITS-1-g]};
    assign gex = tx >= {1'b0, dist_r[g]};
    assign gey = ty >= {1'b0, dist_r[g]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g+1] <= 1'b0;
      end else if (en) begin
        v_r[g+1] <= v_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        remx_r[g+1] <= gex ? DW'(tx - {1'b0, dist_r[g]}) : tx[DW-1:0];
        remy_r[g+1] <= gey ? DW'(ty - {1'b0, dist_r[g]}) : ty[DW-1:0];
        qx_r[g+1]   <= {qx_r[g][DIV_BITS-2:0], gex};
        qy_r[g+1]   <= {qy_r[g][DIV_BITS-2:0], gey};
        nlx_r[g+1]  <= nlx_r[g];
        nly_r[g+1]  <= nly_r[g];
        dist_r[g+1] <= dist_r[g];
        ap_r[g+1]   <= ap_r[g];
        s_r[g+1]    <= s_r[g];
      end
    end

    // rotate by the half yaw in the first stages, then hold
    if (g < CORDIC_STAGES) begin : g_rot
      always_ff @(posedge clk) begin
        if (en) begin
          if (cz_r[g] >= 0) begin
            cx_r[g+1] <= cx_r[g] - (cy_r[g] >>> g);
            cy_r[g+1] <= cy_r[g] + (cx_r[g] >>> g);
            cz_r[g+1] <= cz_r[g] - atan_q30(g);
          end else begin
            cx_r[g+1] <= cx_r[g] + (cy_r[g] >>> g);
            cy_r[g+1] <= cy_r[g] - (cx_r[g] >>> g);
            cz_r[g+1] <= cz_r[g] + atan_q30(g);
          end
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk) begin
        if (en) begin
          cx_r[g+1] <= cx_r[g];
          cy_r[g+1] <= cy_r[g];
          cz_r[g+1] <= cz_r[g];
        end
      end
    end
  end

  assign out_v       = v_r[DIV_BITS];
  assign qx_out      = qx_r[DIV_BITS];
  assign qy_out      = qy_r[DIV_BITS];
  assign cx_out      = cx_r[DIV_BITS];
  assign cy_out      = cy_r[DIV_BITS];
  assign applied_out = ap_r[DIV_BITS];
  assign side_out    = s_r[DIV_BITS];

endmodule

### hw/rtl/standoff_goal_pose.sv
// Top level of the standoff goal pose pipeline.
//
//   channel   direction  handshake         carries
//   in_word   sink       valid/ready       object pose, robot pose, robot_valid
//   out_word  source     valid/ready       goal pose, offset_applied
//   cfg       write      cfg_wr_en         standoff_distance
//
// Accepts one word per cycle while the skid is empty; each result passes through 25 vectoring
// CORDIC stages, 3 multiply stages, 34 divider stages and the output register; the first of
// these 63 registers loads at the edge that takes its word.
// Reset clears all valid bits and loads the standoff with 0.5 m.
// A result held at the output fills a one-word skid; only a full skid freezes the
// whole pipeline and drops in_word.ready.
module standoff_goal_pose import sgp_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  sgp_in_if.sink          in_word,
  sgp_out_if.source       out_word,
  input  logic            cfg_wr_en,
  input  logic [SDW-1:0]  cfg_wr_data
);

  localparam int XU  = CW - 1;
  localparam int GLO = 18;
  localparam int GW  = DIV_BITS + 2;
  localparam logic signed [GW-1:0] S32_MAX = GW'(2147483647);
  localparam logic signed [GW-1:0] S32_MIN = ~S32_MAX;

  typedef struct packed {
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    logic signed [31:0] qz;
    logic signed [31:0] qw;
    logic               applied;
  } res_t;

  logic [SDW-1:0] sd_r;
  logic           en;
  logic           skid_v_r;
  logic           out_v_r;
  res_t           out_r;
  res_t           skid_r;

  // hold the standoff register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd_r <= STANDOFF_RST;
    end else if (cfg_wr_en) begin
      sd_r <= cfg_wr_data;
    end
  end

  assign en            = !skid_v_r;
  assign in_word.ready = en;

  // form the difference vector and pre-rotate into the right half plane
  logic signed [31:0]   rx;
  logic signed [31:0]   ry;
  logic signed [32:0]   dx;
  logic signed [32:0]   dy;
  logic signed [CW-1:0] mx;
  logic signed [CW-1:0] my;
  logic signed [CW-1:0] x0;
  logic signed [CW-1:0] y0;
  logic signed [ZW-1:0] z0;
  logic signed [32:0]   adx;
  logic signed [32:0]   ady;
  side_t                side0;

  always_comb begin
    rx  = in_word.robot_valid ? in_word.robot_x : 32'sd0;
    ry  = in_word.robot_valid ? in_word.robot_y : 32'sd0;
    dx  = 33'(rx) - 33'(in_word.object_x);
    dy  = 33'(ry) - 33'(in_word.object_y);
    mx  = -CW'(dx);
    my  = -CW'(dy);
    if (mx < 0) begin
      if (my > 0) begin
        x0 = my;
        y0 = -mx;
        z0 = HALF_PI;
      end else begin
        x0 = -my;
        y0 = mx;
        z0 = -HALF_PI;
      end
    end else begin
      x0 = mx;
      y0 = my;
      z0 = '0;
    end
    adx       = dx[32] ? -dx : dx;
    ady       = dy[32] ? -dy : dy;
    side0.ox  = in_word.object_x;
    side0.oy  = in_word.object_y;
    side0.qz  = in_word.object_quat_z;
    side0.qw  = in_word.object_quat_w;
    side0.dxn = dx[32];
    side0.dyn = dy[32];
    side0.ax  = adx[31:0];
    side0.ay  = ady[31:0];
  end

  logic                 vec_v;
  logic signed [CW-1:0] vec_x;
  logic signed [ZW-1:0] vec_z;
  side_t                vec_s;

  sgp_vec u_vec (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (in_word.valid),
    .x_in     (x0),
    .y_in     (y0),
    .z_in     (z0),
    .side_in  (side0),
    .out_v    (vec_v),
    .x_out    (vec_x),
    .z_out    (vec_z),
    .side_out (vec_s)
  );

  // first multiply stage: partial products of gain and of standoff
  logic                 m1_v_r;
  logic [GLO+29:0]      pg_lo_r;
  logic [XU-GLO+29:0]   pg_hi_r;
  logic [16+SDW-1:0]    pxl_r;
  logic [16+SDW-1:0]    pxh_r;
  logic [16+SDW-1:0]    pyl_r;
  logic [16+SDW-1:0]    pyh_r;
  logic signed [ZW-1:0] m1_z_r;
  side_t                m1_s_r;
  logic [XU-1:0]        ux;

  assign ux = vec_x[XU-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
    end else if (en) begin
      m1_v_r <= vec_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pg_lo_r <= ux[GLO-1:0] * GAIN_INV;
      pg_hi_r <= ux[XU-1:GLO] * GAIN_INV;
      pxl_r   <= vec_s.ax[15:0] * sd_r;
      pxh_r   <= vec_s.ax[31:16] * sd_r;
      pyl_r   <= vec_s.ay[15:0] * sd_r;
      pyh_r   <= vec_s.ay[31:16] * sd_r;
      m1_z_r  <= vec_z;
      m1_s_r  <= vec_s;
    end
  end

  // second multiply stage: sum partials into distance and products
  logic                 m2_v_r;
  logic [DW-1:0]        m2_dist_r;
  logic [NW-1:0]        m2_px_r;
  logic [NW-1:0]        m2_py_r;
  logic signed [ZW-1:0] m2_z_r;
  side_t                m2_s_r;
  logic [65:0]          gsum;

  assign gsum = (66'(pg_hi_r) << GLO) + 66'(pg_lo_r) + (66'(1) << 29);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_v_r <= 1'b0;
    end else if (en) begin
      m2_v_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_dist_r <= gsum[30 +: DW];
      m2_px_r   <= (NW'(pxh_r) << 16) + NW'(pxl_r);
      m2_py_r   <= (NW'(pyh_r) << 16) + NW'(pyl_r);
      m2_z_r    <= m1_z_r;
      m2_s_r    <= m1_s_r;
    end
  end

  // third stage: rounding numerators, standoff test, half yaw
  logic                 m3_v_r;
  logic [NW-1:0]        m3_nx_r;
  logic [NW-1:0]        m3_ny_r;
  logic [DW-1:0]        m3_dist_r;
  logic signed [ZW-1:0] m3_zh_r;
  logic                 m3_ap_r;
  side_t                m3_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_v_r <= 1'b0;
    end else if (en) begin
      m3_v_r <= m2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m3_nx_r   <= m2_px_r + NW'(m2_dist_r >> 1);
      m3_ny_r   <= m2_py_r + NW'(m2_dist_r >> 1);
      m3_dist_r <= m2_dist_r;
      m3_zh_r   <= m2_z_r >>> 1;
      m3_ap_r   <= m2_dist_r > DW'(sd_r);
      m3_s_r    <= m2_s_r;
    end
  end

  logic                 dr_v;
  logic [DIV_BITS-1:0]  dr_qx;
  logic [DIV_BITS-1:0]  dr_qy;
  logic signed [RW-1:0] dr_cx;
  logic signed [RW-1:0] dr_cy;
  logic                 dr_ap;
  side_t                dr_s;

  sgp_divrot u_divrot (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_v        (m3_v_r),
    .nx_in       (m3_nx_r),
    .ny_in       (m3_ny_r),
    .dist_in     (m3_dist_r),
    .zh_in       (m3_zh_r),
    .applied_in  (m3_ap_r),
    .side_in     (m3_s_r),
    .out_v       (dr_v),
    .qx_out      (dr_qx),
    .qy_out      (dr_qy),
    .cx_out      (dr_cx),
    .cy_out      (dr_cy),
    .applied_out (dr_ap),
    .side_out    (dr_s)
  );

  // apply offset signs, saturate, clamp and select passthrough
  logic signed [GW-1:0] offx;
  logic signed [GW-1:0] offy;
  logic signed [GW-1:0] gxw;
  logic signed [GW-1:0] gyw;
  logic signed [RW-1:0] cz_cl;
  logic signed [RW-1:0] cw_cl;
  res_t                 res;

  always_comb begin
    offx  = signed'({2'b00, dr_qx});
    offy  = signed'({2'b00, dr_qy});
    gxw   = GW'(dr_s.ox) + (dr_s.dxn ? -offx : offx);
    gyw   = GW'(dr_s.oy) + (dr_s.dyn ? -offy : offy);
    cz_cl = (dr_cy > Q30_ONE) ? Q30_ONE : ((dr_cy < -Q30_ONE) ? -Q30_ONE : dr_cy);
    cw_cl = (dr_cx > Q30_ONE) ? Q30_ONE : ((dr_cx < -Q30_ONE) ? -Q30_ONE : dr_cx);
    if (dr_ap) begin
      res.gx = (gxw > S32_MAX) ? 32'sh7fffffff : ((gxw < S32_MIN) ? 32'sh80000000 : gxw[31:0]);
      res.gy = (gyw > S32_MAX) ? 32'sh7fffffff : ((gyw < S32_MIN) ? 32'sh80000000 : gyw[31:0]);
      res.qz = cz_cl[31:0];
      res.qw = cw_cl[31:0];
    end else begin
      res.gx = dr_s.ox;
      res.gy = dr_s.oy;
      res.qz = dr_s.qz;
      res.qw = dr_s.qw;
    end
    res.applied = dr_ap;
  end

  // output register with a one-word skid behind it
  logic take;
  logic load_pipe;

  assign take      = out_v_r && out_word.ready;
  assign load_pipe = en && dr_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (skid_v_r) begin
        out_v_r <= 1'b1;
      end else begin
        out_v_r <= load_pipe || (out_v_r && !take);
      end
      if (take && skid_v_r) begin
        skid_v_r <= 1'b0;
      end else if (load_pipe && out_v_r && !take) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && skid_v_r) begin
      out_r <= skid_r;
    end else if (load_pipe && (!out_v_r || take)) begin
      out_r <= res;
    end
    if (load_pipe && out_v_r && !take) begin
      skid_r <= res;
    end
  end

  assign out_word.valid          = out_v_r;
  assign out_word.goal_x         = out_r.gx;
  assign out_word.goal_y         = out_r.gy;
  assign out_word.goal_quat_z    = out_r.qz;
  assign out_word.goal_quat_w    = out_r.qw;
  assign out_word.offset_applied = out_r.applied;

  // skid holds a word only behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid word without output word");

  // skid fills only when the output was stalled
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_word.ready))
    else $error("skid filled without output stall");

  // computed goal orientation stays within unit range
  a_quat_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_word.offset_applied) |->
      (out_word.goal_quat_z <= 32'sh40000000 && out_word.goal_quat_z >= -32'sh40000000 &&
       out_word.goal_quat_w <= 32'sh40000000 && out_word.goal_quat_w >= -32'sh40000000))
    else $error("goal quaternion out of range");

endmodule
